// File: rtl/ttc_pkg.sv
package ttc_pkg;

    typedef enum logic [1:0] {
        MODE_HEX5 = 2'd0,
        MODE_HEX8 = 2'd1,
        MODE_BIN  = 2'd2,
        MODE_TELE = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        PS_BEGIN    = 4'd0,
        PS_HEX      = 4'd1,
        PS_EOL      = 4'd2,
        PS_HASH     = 4'd3,
        PS_SKIP     = 4'd4,
        PS_SKIPHASH = 4'd5,
        PS_U5       = 4'd6,
        PS_U4       = 4'd7,
        PS_U3       = 4'd8,
        PS_U2       = 4'd9,
        PS_U1       = 4'd10
    } t_pstate;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_LET  = 2'd1,
        SH_FIG  = 2'd2
    } t_shift;

    typedef enum logic [1:0] {
        TK_LET  = 2'd0,
        TK_FIG  = 2'd1,
        TK_KEEP = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] code;
    } t_tele;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // one queue entry: optional shift code, then the character code
    typedef struct packed {
        logic       has_shift;
        logic       shift_let;
        logic [7:0] code;
    } t_entry;

    localparam logic [7:0] CODE_LET_SHIFT = 8'd31;
    localparam logic [7:0] CODE_FIG_SHIFT = 8'd27;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_S_LC = 8'h73;
    localparam logic [7:0] CH_S_UC = 8'h53;
    localparam logic [7:0] CH_E_LC = 8'h65;
    localparam logic [7:0] CH_E_UC = 8'h45;

    function automatic t_hex hex_val(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b1;
        r.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r.val = c[3:0] + 4'd9;
        end else begin
            r.ok  = 1'b0;
            r.val = 4'd0;
        end
        return r;
    endfunction

    function automatic t_tele tele_map(input logic [30:0] w);
        t_tele r;
        r.kind = TK_FIG;
        r.code = 5'd0;
        if ((w >= 31'h61 && w <= 31'h7A) || (w >= 31'h41 && w <= 31'h5A)) begin
            r.kind = TK_LET;
            r.code = w[4:0];
        end else begin
            case (w)
                31'h31:           r.code = 5'd1;
                31'h32:           r.code = 5'd2;
                31'h2A:           r.code = 5'd3;
                31'h34:           r.code = 5'd4;
                31'h24, 31'h3C:   r.code = 5'd5;
                31'h3D:           r.code = 5'd6;
                31'h37:           r.code = 5'd7;
                31'h38:           r.code = 5'd8;
                31'h3B, 31'h27:   r.code = 5'd9;
                31'h2C:           r.code = 5'd10;
                31'h2B:           r.code = 5'd11;
                31'h3A:           r.code = 5'd12;
                31'h2D:           r.code = 5'd13;
                31'h2E:           r.code = 5'd14;
                31'h25, 31'h3E:   r.code = 5'd15;
                31'h30:           r.code = 5'd16;
                31'h28:           r.code = 5'd17;
                31'h29:           r.code = 5'd18;
                31'h33:           r.code = 5'd19;
                31'hB4, 31'h3F:   r.code = 5'd20;
                31'h35:           r.code = 5'd21;
                31'h36:           r.code = 5'd22;
                31'h2F:           r.code = 5'd23;
                31'h40:           r.code = 5'd24;
                31'h39:           r.code = 5'd25;
                31'h60, 31'h23, 31'hA3, 31'h2192: r.code = 5'd26;
                31'h20: begin
                    r.kind = TK_KEEP;
                    r.code = 5'd28;
                end
                31'h0D: begin
                    r.kind = TK_KEEP;
                    r.code = 5'd29;
                end
                31'h0A: begin
                    r.kind = TK_KEEP;
                    r.code = 5'd30;
                end
                default: begin
                    r.kind = TK_KEEP;
                    r.code = 5'd0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

// File: rtl/ttc_front.sv
module ttc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [1:0]      i_cfg_wr_data,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_start_of_batch,
    output logic            o_wr,
    output ttc_pkg::t_entry o_entry
);
    import ttc_pkg::*;

    t_mode       r_mode, n_mode;
    t_pstate     r_parse, n_parse;
    logic [3:0]  r_digit, n_digit;
    logic [30:0] r_accum, n_accum;
    t_shift      r_shift, n_shift;

    t_hex        hv;
    t_tele       tm;
    t_shift      base;
    t_shift      sh;
    logic [30:0] acc_next;
    logic [30:0] w;
    logic        w_ok;
    logic [7:0]  c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HEX5;
            r_parse <= PS_BEGIN;
            r_digit <= 4'd0;
            r_accum <= 31'd0;
            r_shift <= SH_NONE;
        end else begin
            r_mode  <= n_mode;
            r_parse <= n_parse;
            r_digit <= n_digit;
            r_accum <= n_accum;
            r_shift <= n_shift;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_parse  = r_parse;
        n_digit  = r_digit;
        n_accum  = r_accum;
        n_shift  = r_shift;
        o_wr     = 1'b0;
        o_entry  = '0;
        c        = i_data_byte;
        hv       = hex_val(c);
        base     = i_start_of_batch ? SH_NONE : r_shift;
        acc_next = {r_accum[24:0], c[5:0]};
        w        = 31'd0;
        w_ok     = 1'b0;
        tm       = tele_map(w);
        sh       = base;

        if (i_cfg_wr_en) begin
            n_mode = t_mode'(i_cfg_wr_data);
        end

        if (i_accept) begin
            n_shift = base;
            case (r_mode)
                MODE_BIN: begin
                    o_wr         = 1'b1;
                    o_entry.code = c;
                end
                MODE_HEX5, MODE_HEX8: begin
                    case (r_parse)
                        PS_HEX: begin
                            if (hv.ok) begin
                                o_wr         = 1'b1;
                                o_entry.code = {r_digit, hv.val};
                                if (r_mode == MODE_HEX5) begin
                                    o_entry.code = {3'b000, r_digit[0], hv.val};
                                end
                            end
                            n_parse = PS_EOL;
                        end
                        PS_EOL: begin
                            if (c == CH_CR || c == CH_LF) begin
                                n_parse = PS_BEGIN;
                            end
                        end
                        PS_HASH: begin
                            if (c == CH_S_LC || c == CH_S_UC) begin
                                n_parse = PS_SKIP;
                            end else if (c == CH_E_LC || c == CH_E_UC) begin
                                n_parse = PS_EOL;
                            end
                        end
                        PS_SKIP: begin
                            if (c == CH_CR || c == CH_LF) begin
                                n_parse = PS_SKIPHASH;
                            end
                        end
                        PS_SKIPHASH: begin
                            if (c == CH_HASH) begin
                                n_parse = PS_HASH;
                            end
                        end
                        default: begin
                            n_parse = PS_BEGIN;
                            if (c == CH_HASH) begin
                                n_parse = PS_HASH;
                            end else if (hv.ok) begin
                                n_parse = PS_HEX;
                                n_digit = hv.val;
                            end
                        end
                    endcase
                end
                default: begin
                    if (r_parse >= PS_U5 && r_parse < PS_U1) begin
                        n_accum = acc_next;
                        n_parse = t_pstate'(r_parse + 4'd1);
                    end else if (r_parse == PS_U1) begin
                        n_accum = acc_next;
                        n_parse = PS_BEGIN;
                        w       = acc_next;
                        w_ok    = 1'b1;
                    end else begin
                        n_parse = PS_BEGIN;
                        if (!c[7] || c == 8'hFE || c == 8'hFF) begin
                            w    = {23'd0, c};
                            w_ok = 1'b1;
                        end else if (c[7:5] == 3'b110) begin
                            n_accum = {26'd0, c[4:0]};
                            n_parse = PS_U1;
                        end else if (c[7:4] == 4'b1110) begin
                            n_accum = {27'd0, c[3:0]};
                            n_parse = PS_U2;
                        end else if (c[7:3] == 5'b11110) begin
                            n_accum = {28'd0, c[2:0]};
                            n_parse = PS_U3;
                        end else if (c[7:2] == 6'b111110) begin
                            n_accum = {29'd0, c[1:0]};
                            n_parse = PS_U4;
                        end else if (c[7:1] == 7'b1111110) begin
                            n_accum = {30'd0, c[0]};
                            n_parse = PS_U5;
                        end else begin
                            n_accum = {25'd0, c[5:0]};
                        end
                    end
                    if (w_ok) begin
                        tm = tele_map(w);
                        case (tm.kind)
                            TK_LET:  sh = SH_LET;
                            TK_FIG:  sh = SH_FIG;
                            default: sh = base;
                        endcase
                        o_wr              = 1'b1;
                        o_entry.has_shift = (sh != base);
                        o_entry.shift_let = (sh == SH_LET);
                        o_entry.code      = {3'b000, tm.code};
                        n_shift           = sh;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/ttc_back.sv
module ttc_back #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ttc_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output logic [7:0]      o_code,
    output logic            o_last
);
    import ttc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            r_phase, n_phase;

    t_entry          head;
    logic            shift_pending;
    logic            pop_ok;
    logic            item_done;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_phase  <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_phase  <= n_phase;
        end
    end

    always_comb begin
        head          = r_mem[r_rd_ptr];
        o_empty       = (r_count == '0);
        o_full        = (r_count == CW'(DEPTH));
        shift_pending = head.has_shift && !r_phase;
        o_last        = !shift_pending;
        o_code        = head.code;
        if (shift_pending) begin
            o_code = head.shift_let ? CODE_LET_SHIFT : CODE_FIG_SHIFT;
        end
        pop_ok    = i_pop && !o_empty;
        item_done = pop_ok && !shift_pending;

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        n_phase  = r_phase;

        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_phase = shift_pending;
        end
        if (item_done) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_wr, item_done})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

endmodule

// File: rtl/tape_text_to_telecode_converter_unit.sv
// Tape text to telecode converter.
// Input queue side: drive i_data_byte and i_start_of_batch with i_push; an item
// is taken at a clock edge with i_push high and o_full low.
// Result queue side: while o_empty is low, o_code and o_last show the oldest
// code; it is taken at an edge with i_pop high. o_last marks the final code of
// an input item. Items that produce no code (hex comments, UTF-8 lead bytes)
// leave nothing in the result queue.
// Configuration: i_cfg_wr_en with i_cfg_wr_data writes the mode register
// (0 hex five-bit, 1 hex eight-bit, 2 binary, 3 telecode); write only when idle.
// An item's entry is written to the queue at the edge that takes it.
// Throughput: one item per cycle while o_full is low; an item that needs
// a shift code gives two codes to pop, so the pop side sets the sustained rate.
// The front classifies each item in its accept cycle and writes at most one
// entry to a QUEUE_DEPTH-entry queue; the back drains shift then character code.
// Reset: mode hex five-bit, parser at line start, shift none, queue empty.
// When the receiver stalls, the queue fills and o_full holds off new items.
module tape_text_to_telecode_converter_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_batch,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_code,
    output logic       o_last
);
    import ttc_pkg::*;

    logic   accept;
    logic   wr;
    t_entry entry;

    assign accept = i_push && !o_full;

    ttc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_start_of_batch (i_start_of_batch),
        .o_wr             (wr),
        .o_entry          (entry)
    );

    ttc_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_entry (entry),
        .i_pop   (i_pop),
        .o_full  (o_full),
        .o_empty (o_empty),
        .o_code  (o_code),
        .o_last  (o_last)
    );

endmodule
